// ===== hdl/lcdspi_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdspi_pkg
// Shared types and constants for the three-wire 9-bit LCD serial master.
// ----------------------------------------------------------------------------
package lcdspi_pkg;

    // request kinds carried in the input tuser field
    localparam logic [1:0] MODE_CMD   = 2'd0;
    localparam logic [1:0] MODE_PARAM = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_RSVD  = 2'd3;

    localparam int unsigned PHASE_W        = 10;
    localparam logic [PHASE_W-1:0] PHASE_RESET = 10'd50;

    // input and output payload widths, padded to whole bytes
    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 16;

    // pin sequencer states
    typedef enum logic [14:0] {
        ST_IDLE  = 15'b000000000000001,
        ST_CSHI  = 15'b000000000000010,
        ST_CLKHI = 15'b000000000000100,
        ST_CSLO  = 15'b000000000001000,
        ST_CLKLO = 15'b000000000010000,
        ST_DC    = 15'b000000000100000,
        ST_DCCLK = 15'b000000001000000,
        ST_BLO   = 15'b000000010000000,
        ST_BDATA = 15'b000000100000000,
        ST_BHI   = 15'b000001000000000,
        ST_DUMLO = 15'b000010000000000,
        ST_DUMHI = 15'b000100000000000,
        ST_RLO   = 15'b001000000000000,
        ST_RHI   = 15'b010000000000000,
        ST_ENDCS = 15'b100000000000000
    } lcdspi_state_t;

    // one tick worth of input
    typedef struct packed {
        logic       start_req;
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic [2:0] read_count;
        logic       sdo_level;
    } lcdspi_tick_t;

    // one tick worth of result
    typedef struct packed {
        logic       cs_pin;
        logic       sclk_pin;
        logic       sdi_pin;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_data;
        logic       read_last;
    } lcdspi_result_t;

endpackage

// ===== hdl/lcdspi_engine.sv =====
// ----------------------------------------------------------------------------
// lcdspi_engine
// Pin sequencer state and the per-tick next-state logic of the serial master.
// ----------------------------------------------------------------------------
module lcdspi_engine #(
    parameter int unsigned MAX_READ_BYTES = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lcdspi_pkg::PHASE_W-1:0]       cfg_wdata,
    input  logic                                 step_en,
    input  lcdspi_pkg::lcdspi_tick_t             tick,
    output lcdspi_pkg::lcdspi_result_t           result
);
    import lcdspi_pkg::*;

    localparam logic [3:0] MAX_BYTES = 4'(MAX_READ_BYTES);

    lcdspi_state_t      state_reg, state_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] hold_reg, hold_next, hold_inc;
    logic [2:0]         bit_reg, bit_next;
    logic [2:0]         byte_reg, byte_next;
    logic [1:0]         kind_reg, kind_next;
    logic [7:0]         shift_reg, shift_next;
    logic [2:0]         wanted_reg, wanted_next;
    logic               cs_reg, cs_next;
    logic               sclk_reg, sclk_next;
    logic               sdi_reg, sdi_next;
    logic               rvalid;
    logic [7:0]         rdata;
    logic               rlast;
    logic [3:0]         byte_plus;

    assign hold_inc  = hold_reg + 10'd1;
    assign byte_plus = {1'b0, byte_reg} + 4'd1;

    // next state for one tick
    always_comb
    begin
        state_next  = state_reg;
        hold_next   = hold_reg;
        bit_next    = bit_reg;
        byte_next   = byte_reg;
        kind_next   = kind_reg;
        shift_next  = shift_reg;
        wanted_next = wanted_reg;
        cs_next     = cs_reg;
        sclk_next   = sclk_reg;
        sdi_next    = sdi_reg;
        rvalid      = 1'b0;
        rdata       = '0;
        rlast       = 1'b0;
        if (state_reg != ST_IDLE)
        begin
            hold_next = hold_inc;
            if (hold_inc >= phase_reg)
            begin
                hold_next = '0;
                unique case (state_reg)
                    ST_CSHI:
                    begin
                        state_next = ST_CLKHI;
                        sclk_next  = 1'b1;
                    end
                    ST_CLKHI:
                    begin
                        state_next = ST_CSLO;
                        cs_next    = 1'b0;
                    end
                    ST_CSLO:
                    begin
                        state_next = ST_CLKLO;
                        sclk_next  = 1'b0;
                    end
                    ST_CLKLO:
                    begin
                        state_next = ST_DC;
                        sdi_next   = (kind_reg == MODE_PARAM);
                    end
                    ST_DC:
                    begin
                        state_next = ST_DCCLK;
                        sclk_next  = 1'b1;
                    end
                    ST_DCCLK:
                    begin
                        bit_next   = 3'd7;
                        state_next = ST_BLO;
                        sclk_next  = 1'b0;
                    end
                    ST_BLO:
                    begin
                        state_next = ST_BDATA;
                        sdi_next   = shift_reg[bit_reg];
                    end
                    ST_BDATA:
                    begin
                        state_next = ST_BHI;
                        sclk_next  = 1'b1;
                    end
                    ST_BHI:
                    begin
                        if (bit_reg != 3'd0)
                        begin
                            bit_next   = bit_reg - 3'd1;
                            state_next = ST_BLO;
                            sclk_next  = 1'b0;
                        end
                        else if (kind_reg == MODE_READ && wanted_reg > 3'd1)
                        begin
                            state_next = ST_DUMLO;
                            sclk_next  = 1'b0;
                        end
                        else if (kind_reg == MODE_READ && wanted_reg != 3'd0)
                        begin
                            bit_next   = 3'd7;
                            byte_next  = 3'd0;
                            state_next = ST_RLO;
                            sclk_next  = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_ENDCS;
                            cs_next    = 1'b1;
                        end
                    end
                    ST_DUMLO:
                    begin
                        state_next = ST_DUMHI;
                        sclk_next  = 1'b1;
                    end
                    ST_DUMHI:
                    begin
                        bit_next   = 3'd7;
                        byte_next  = 3'd0;
                        state_next = ST_RLO;
                        sclk_next  = 1'b0;
                    end
                    ST_RLO:
                    begin
                        // sample sdo at the end of the low phase
                        shift_next[bit_reg] = tick.sdo_level;
                        if (bit_reg == 3'd0)
                        begin
                            rvalid = 1'b1;
                            rdata  = shift_next;
                            rlast  = (byte_plus >= {1'b0, wanted_reg});
                        end
                        state_next = ST_RHI;
                        sclk_next  = 1'b1;
                    end
                    ST_RHI:
                    begin
                        if (bit_reg != 3'd0)
                        begin
                            bit_next   = bit_reg - 3'd1;
                            state_next = ST_RLO;
                            sclk_next  = 1'b0;
                        end
                        else if (byte_plus < {1'b0, wanted_reg})
                        begin
                            byte_next  = byte_plus[2:0];
                            bit_next   = 3'd7;
                            state_next = ST_RLO;
                            sclk_next  = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_ENDCS;
                            cs_next    = 1'b1;
                        end
                    end
                    ST_ENDCS:
                    begin
                        if (kind_reg == MODE_READ)
                        begin
                            sdi_next = 1'b0;
                        end
                        state_next = ST_IDLE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
        end
        else if (tick.start_req && tick.mode != MODE_RSVD)
        begin
            // new request from idle
            kind_next  = tick.mode;
            shift_next = tick.data_byte;
            bit_next   = 3'd7;
            byte_next  = 3'd0;
            hold_next  = '0;
            if (tick.mode == MODE_READ)
            begin
                if ({1'b0, tick.read_count} > MAX_BYTES)
                    wanted_next = MAX_BYTES[2:0];
                else
                    wanted_next = tick.read_count;
            end
            else
            begin
                wanted_next = 3'd0;
            end
            if (tick.mode == MODE_PARAM)
            begin
                state_next = ST_CSLO;
                cs_next    = 1'b0;
            end
            else
            begin
                state_next = ST_CSHI;
                cs_next    = 1'b1;
            end
        end
    end

    // result of this tick
    always_comb
    begin
        result.cs_pin     = cs_next;
        result.sclk_pin   = sclk_next;
        result.sdi_pin    = sdi_next;
        result.busy_res   = (state_next != ST_IDLE);
        result.read_valid = rvalid;
        result.read_data  = rdata;
        result.read_last  = rlast;
    end

    // phase length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PHASE_RESET;
        else if (cfg_we)
            phase_reg <= cfg_wdata;
    end

    // sequencer state, advanced once per accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            hold_reg   <= '0;
            bit_reg    <= 3'd7;
            byte_reg   <= 3'd0;
            kind_reg   <= MODE_CMD;
            shift_reg  <= '0;
            wanted_reg <= 3'd0;
            cs_reg     <= 1'b0;
            sclk_reg   <= 1'b0;
            sdi_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            state_reg  <= state_next;
            hold_reg   <= hold_next;
            bit_reg    <= bit_next;
            byte_reg   <= byte_next;
            kind_reg   <= kind_next;
            shift_reg  <= shift_next;
            wanted_reg <= wanted_next;
            cs_reg     <= cs_next;
            sclk_reg   <= sclk_next;
            sdi_reg    <= sdi_next;
        end
    end

endmodule

// ===== hdl/lcd_three_wire_spi_master_top.sv =====
// ----------------------------------------------------------------------------
// lcd_three_wire_spi_master_top
// Tick-driven three-wire 9-bit serial master for an LCD panel controller.
//
// channel  | direction | payload
// ---------+-----------+-------------------------------------------------------
// s_*      | in        | tdata: start_req, data_byte, read_count, sdo_level
//          |           | tuser: mode
// m_*      | out       | tdata: cs, sclk, sdi, busy, read_data
//          |           | tuser: read_valid, tlast: read_last
// cfg_*    | in        | phase_ticks, written when cfg_we is high
//
// Each input transaction is one tick of the sequencer: one result per tick,
// one tick accepted every cycle unless stalled; results are registered.
// The pin sequencer state and next-state logic form the only path, from the
// state registers through the engine into the output register.
// Input is stalled only while the output register is full and not taken.
// Reset clears the sequencer to idle with all pins low and phase_ticks 50.
// ----------------------------------------------------------------------------
module lcd_three_wire_spi_master_top #(
    parameter int unsigned MAX_READ_BYTES = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lcdspi_pkg::PHASE_W-1:0]       cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [0] start_req, [8:1] data_byte, [11:9] read_count, [12] sdo_level
    input  logic [lcdspi_pkg::S_DATA_W-1:0]      s_tdata,
    // [1:0] mode
    input  logic [1:0]                           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] cs_pin, [1] sclk_pin, [2] sdi_pin, [3] busy_res, [11:4] read_data
    output logic [lcdspi_pkg::M_DATA_W-1:0]      m_tdata,
    // [0] read_valid
    output logic                                 m_tuser,
    output logic                                 m_tlast
);
    import lcdspi_pkg::*;

    lcdspi_tick_t   tick;
    lcdspi_result_t result;
    logic           accept;
    logic           m_valid_reg;
    lcdspi_result_t m_result_reg;

    // unpack the input transaction
    always_comb
    begin
        tick.start_req  = s_tdata[0];
        tick.data_byte  = s_tdata[8:1];
        tick.read_count = s_tdata[11:9];
        tick.sdo_level  = s_tdata[12];
        tick.mode       = s_tuser;
    end

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    lcdspi_engine #(
        .MAX_READ_BYTES (MAX_READ_BYTES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step_en   (accept),
        .tick      (tick),
        .result    (result)
    );

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (s_tready)
            m_valid_reg <= s_tvalid;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (accept)
            m_result_reg <= result;
    end

    // pack the output transaction
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_result_reg.read_data, m_result_reg.busy_res,
                       m_result_reg.sdi_pin, m_result_reg.sclk_pin,
                       m_result_reg.cs_pin};
    assign m_tuser  = m_result_reg.read_valid;
    assign m_tlast  = m_result_reg.read_last;

    // a completed read byte always arrives inside a busy request
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[3])
        else $error("read byte reported while not busy");

    // no read data or last mark without a read byte
    a_read_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[11:4] == 8'd0) && !m_tlast)
        else $error("read fields set without a read byte");

    // an empty output register never stalls the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

endmodule

// ===== test/lcd_three_wire_spi_master_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_three_wire_spi_master_top_tb
// Self-checking bench for the three-wire 9-bit LCD serial master. Each input
// transaction is one sequencer tick; a model in the bench predicts the pin
// levels, busy flag and read bytes of every tick and checks each output
// transaction against it, under random stalls on both streams.
// ----------------------------------------------------------------------------
module lcd_three_wire_spi_master_top_tb;

    import lcdspi_pkg::*;

    localparam int unsigned READ_MAX   = 4;
    localparam int unsigned HOLD_LEN   = 80;
    localparam int unsigned IDLE_LIMIT = 2000;

    typedef enum logic [1:0] {
        SDO_LOW,
        SDO_HIGH,
        SDO_RANDOM
    } sdo_fill_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [PHASE_W-1:0]    cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // stimulus and prediction stores
    lcdspi_tick_t   tick_queue[$];
    lcdspi_tick_t   cur_tick;
    lcdspi_result_t predicted_outputs[$];
    int unsigned    ticks_queued = 0;
    int unsigned    err_count = 0;
    logic           burst_mode = 1'b0;
    int unsigned    long_hold_asks = 0;
    int unsigned    long_hold_done = 0;
    int unsigned    long_hold_left = 0;
    int unsigned    send_gap = 0;
    int unsigned    recv_stall = 0;
    int unsigned    idle_cycles = 0;

    // sequencer model state
    logic [PHASE_W-1:0] phase_ticks_model = PHASE_RESET;
    lcdspi_state_t      seq_state = ST_IDLE;
    logic [9:0]         hold_cnt = '0;
    logic [2:0]         bit_idx = 3'd7;
    logic [2:0]         byte_idx = '0;
    logic [1:0]         req_kind = MODE_CMD;
    logic [7:0]         shift_reg = '0;
    logic [2:0]         bytes_wanted = '0;
    logic               pin_cs = 1'b0;
    logic               pin_sclk = 1'b0;
    logic               pin_sdi = 1'b0;

    lcd_three_wire_spi_master_top #(
        .MAX_READ_BYTES(READ_MAX)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // enter a pin phase and drive the pin that it changes
    function automatic void enter_phase(input lcdspi_state_t st);
        seq_state = st;
        hold_cnt  = '0;
        case (st)
            ST_CSHI:  pin_cs = 1'b1;
            ST_CLKHI: pin_sclk = 1'b1;
            ST_CSLO:  pin_cs = 1'b0;
            ST_CLKLO: pin_sclk = 1'b0;
            ST_DC:    pin_sdi = (req_kind == MODE_PARAM);
            ST_DCCLK: pin_sclk = 1'b1;
            ST_BLO:   pin_sclk = 1'b0;
            ST_BDATA: pin_sdi = shift_reg[bit_idx];
            ST_BHI:   pin_sclk = 1'b1;
            ST_DUMLO: pin_sclk = 1'b0;
            ST_DUMHI: pin_sclk = 1'b1;
            ST_RLO:   pin_sclk = 1'b0;
            ST_RHI:   pin_sclk = 1'b1;
            ST_ENDCS: pin_cs = 1'b1;
            default:  ;
        endcase
    endfunction

    // advance the sequencer model by one tick and return its outputs
    function automatic lcdspi_result_t sequencer_tick(input lcdspi_tick_t t);
        lcdspi_result_t r;
        r = '0;
        if (seq_state != ST_IDLE)
        begin
            hold_cnt = hold_cnt + 10'd1;
            if (hold_cnt >= phase_ticks_model)
            begin
                case (seq_state)
                    ST_CSHI:  enter_phase(ST_CLKHI);
                    ST_CLKHI: enter_phase(ST_CSLO);
                    ST_CSLO:  enter_phase(ST_CLKLO);
                    ST_CLKLO: enter_phase(ST_DC);
                    ST_DC:    enter_phase(ST_DCCLK);
                    ST_DCCLK:
                    begin
                        bit_idx = 3'd7;
                        enter_phase(ST_BLO);
                    end
                    ST_BLO:   enter_phase(ST_BDATA);
                    ST_BDATA: enter_phase(ST_BHI);
                    ST_BHI:
                    begin
                        if (bit_idx != 3'd0)
                        begin
                            bit_idx = bit_idx - 3'd1;
                            enter_phase(ST_BLO);
                        end
                        else if (req_kind == MODE_READ && bytes_wanted > 3'd1)
                        begin
                            enter_phase(ST_DUMLO);
                        end
                        else if (req_kind == MODE_READ && bytes_wanted != 3'd0)
                        begin
                            bit_idx  = 3'd7;
                            byte_idx = '0;
                            enter_phase(ST_RLO);
                        end
                        else
                        begin
                            enter_phase(ST_ENDCS);
                        end
                    end
                    ST_DUMLO: enter_phase(ST_DUMHI);
                    ST_DUMHI:
                    begin
                        bit_idx  = 3'd7;
                        byte_idx = '0;
                        enter_phase(ST_RLO);
                    end
                    ST_RLO:
                    begin
                        // sample on the last tick of the low phase
                        shift_reg[bit_idx] = t.sdo_level;
                        if (bit_idx == 3'd0)
                        begin
                            r.read_valid = 1'b1;
                            r.read_data  = shift_reg;
                            r.read_last  = ({1'b0, byte_idx} + 4'd1) >= {1'b0, bytes_wanted};
                        end
                        enter_phase(ST_RHI);
                    end
                    ST_RHI:
                    begin
                        if (bit_idx != 3'd0)
                        begin
                            bit_idx = bit_idx - 3'd1;
                            enter_phase(ST_RLO);
                        end
                        else if (({1'b0, byte_idx} + 4'd1) < {1'b0, bytes_wanted})
                        begin
                            byte_idx = byte_idx + 3'd1;
                            bit_idx  = 3'd7;
                            enter_phase(ST_RLO);
                        end
                        else
                        begin
                            enter_phase(ST_ENDCS);
                        end
                    end
                    default:
                    begin
                        // end of frame, a read also parks sdi low
                        if (req_kind == MODE_READ)
                            pin_sdi = 1'b0;
                        seq_state = ST_IDLE;
                        hold_cnt  = '0;
                    end
                endcase
            end
        end
        else if (t.start_req && t.mode != MODE_RSVD)
        begin
            req_kind  = t.mode;
            shift_reg = t.data_byte;
            bit_idx   = 3'd7;
            byte_idx  = '0;
            if (t.mode == MODE_READ)
                bytes_wanted = (t.read_count > READ_MAX) ? 3'(READ_MAX) : t.read_count;
            else
                bytes_wanted = '0;
            enter_phase(t.mode == MODE_PARAM ? ST_CSLO : ST_CSHI);
        end
        r.cs_pin   = pin_cs;
        r.sclk_pin = pin_sclk;
        r.sdi_pin  = pin_sdi;
        r.busy_res = (seq_state != ST_IDLE);
        return r;
    endfunction

    // queue n plain ticks, starts ignored while busy
    task automatic queue_ticks(input int unsigned n, input int unsigned start_pct,
                               input sdo_fill_t fill);
        lcdspi_tick_t t;
        repeat (n)
        begin
            t.start_req  = ($urandom_range(0, 99) < start_pct);
            t.mode       = 2'($urandom_range(0, 3));
            t.data_byte  = 8'($urandom_range(0, 255));
            t.read_count = 3'($urandom_range(0, 7));
            case (fill)
                SDO_LOW:  t.sdo_level = 1'b0;
                SDO_HIGH: t.sdo_level = 1'b1;
                default:  t.sdo_level = 1'($urandom_range(0, 1));
            endcase
            tick_queue.push_back(t);
            ticks_queued++;
        end
    endtask

    // queue a start and enough ticks for the request to run out, capped by max_span
    task automatic queue_request(input logic [1:0] mode, input logic [7:0] data,
                                 input logic [2:0] count, input sdo_fill_t fill,
                                 input int unsigned max_span);
        lcdspi_tick_t t;
        int unsigned  phases;
        int unsigned  nbytes;
        int unsigned  span;
        t.start_req  = 1'b1;
        t.mode       = mode;
        t.data_byte  = data;
        t.read_count = count;
        t.sdo_level  = 1'($urandom_range(0, 1));
        tick_queue.push_back(t);
        ticks_queued++;
        phases = 0;
        if (mode == MODE_CMD)
            phases = 31;
        else if (mode == MODE_PARAM)
            phases = 29;
        else if (mode == MODE_READ)
        begin
            nbytes = (count > READ_MAX) ? READ_MAX : count;
            phases = 31 + ((nbytes > 1) ? 2 : 0) + 16 * nbytes;
        end
        span = phases * ((phase_ticks_model == 0) ? 1 : phase_ticks_model);
        if (span > max_span)
            span = max_span;
        queue_ticks(span + $urandom_range(0, 2), 20, fill);
    endtask

    // wait until every queued tick has been taken and checked
    task automatic wait_drained();
        while (tick_queue.size() != 0 || s_tvalid || predicted_outputs.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_phase_ticks(input logic [PHASE_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        phase_ticks_model = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // sender: one tick per transaction, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin : sender
        lcdspi_tick_t   nxt;
        lcdspi_result_t pred;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pred = sequencer_tick(cur_tick);
                predicted_outputs.push_back(pred);
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (tick_queue.size() != 0)
                begin
                    nxt      = tick_queue.pop_front();
                    cur_tick = nxt;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, nxt.sdo_level, nxt.read_count, nxt.data_byte,
                                 nxt.start_req};
                    s_tuser  <= nxt.mode;
                    send_gap = burst_mode ? 0 : $urandom_range(0, 11);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge clk or negedge rst_n)
    begin : receiver
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (long_hold_left == 0 && long_hold_done != long_hold_asks)
            begin
                long_hold_done++;
                long_hold_left = HOLD_LEN;
            end
            if (long_hold_left != 0)
            begin
                long_hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (m_tvalid && m_tready)
                    recv_stall = burst_mode ? 0 : $urandom_range(0, 11);
                if (recv_stall != 0)
                begin
                    recv_stall--;
                    m_tready <= 1'b0;
                end
                else
                begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            err_count++;
        end
    endtask

    // compare each output transaction with the oldest prediction
    always @(posedge clk)
    begin : result_check
        lcdspi_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (predicted_outputs.size() == 0)
            begin
                $error("output transaction with no prediction pending: tdata %0h", m_tdata);
                err_count++;
            end
            else
            begin
                want = predicted_outputs.pop_front();
                check_field("cs_pin", want.cs_pin, m_tdata[0]);
                check_field("sclk_pin", want.sclk_pin, m_tdata[1]);
                check_field("sdi_pin", want.sdi_pin, m_tdata[2]);
                check_field("busy_res", want.busy_res, m_tdata[3]);
                check_field("read_data", want.read_data, m_tdata[11:4]);
                check_field("read_valid", want.read_valid, m_tuser);
                check_field("read_last", want.read_last, m_tlast);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial
    begin : stimulus
        int unsigned pick;
        logic [1:0]  mode;
        logic [7:0]  data;
        logic [2:0]  count;
        sdo_fill_t   fill;
        logic        first_phase;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset hold time, then lower it while a command is mid-phase
        queue_ticks(3, 0, SDO_RANDOM);
        queue_request(MODE_CMD, 8'hA5, 3'd0, SDO_RANDOM, 60);
        wait_drained();
        write_phase_ticks(10'd1);
        queue_ticks(40, 0, SDO_RANDOM);

        // directed requests at the shortest hold
        queue_request(MODE_CMD, 8'h00, 3'd0, SDO_RANDOM, 1000);
        queue_request(MODE_CMD, 8'hFF, 3'd0, SDO_RANDOM, 1000);
        queue_request(MODE_PARAM, 8'h00, 3'd0, SDO_RANDOM, 1000);
        queue_request(MODE_PARAM, 8'hFF, 3'd0, SDO_RANDOM, 1000);
        queue_request(MODE_RSVD, 8'h3C, 3'd1, SDO_RANDOM, 1000);
        queue_request(MODE_READ, 8'h04, 3'd0, SDO_RANDOM, 1000);
        queue_request(MODE_READ, 8'hDA, 3'd1, SDO_HIGH, 1000);
        queue_request(MODE_READ, 8'h0A, 3'd2, SDO_LOW, 1000);
        queue_request(MODE_READ, 8'h09, 3'd4, SDO_RANDOM, 1000);
        queue_request(MODE_READ, 8'hDB, 3'd7, SDO_RANDOM, 1000);
        queue_request(MODE_READ, 8'hDC, 3'd5, SDO_HIGH, 1000);
        wait_drained();

        // zero hold behaves as one
        write_phase_ticks(10'd0);
        queue_request(MODE_CMD, 8'h5A, 3'd0, SDO_RANDOM, 1000);
        queue_request(MODE_READ, 8'h81, 3'd3, SDO_RANDOM, 1000);
        wait_drained();

        // longest hold, then lowered while the first phase is still held
        write_phase_ticks(10'd1023);
        queue_request(MODE_PARAM, 8'hC3, 3'd0, SDO_RANDOM, 60);
        wait_drained();
        write_phase_ticks(10'd1);
        queue_ticks(40, 0, SDO_RANDOM);
        wait_drained();

        // random requests under several hold settings
        first_phase = 1'b1;
        while (ticks_queued < 1100)
        begin
            pick = $urandom_range(0, 5);
            if (pick <= 2)
                write_phase_ticks(10'd1);
            else if (pick == 3)
                write_phase_ticks(10'd2);
            else if (pick == 4)
                write_phase_ticks(10'd3);
            else
                write_phase_ticks(10'($urandom_range(1, 6)));
            burst_mode = !first_phase && ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 5))
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise: random ticks with random starts
                    queue_ticks($urandom_range(1, 8), 50, SDO_RANDOM);
                end
                else
                begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        mode = MODE_RSVD;
                    else if (pick <= 6)
                        mode = MODE_CMD;
                    else if (pick <= 12)
                        mode = MODE_PARAM;
                    else
                        mode = MODE_READ;
                    pick = $urandom_range(0, 7);
                    data = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF :
                           8'($urandom_range(0, 255));
                    count = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(0, 7)) :
                            3'($urandom_range(1, 4));
                    pick = $urandom_range(0, 5);
                    fill = (pick == 0) ? SDO_LOW : (pick == 1) ? SDO_HIGH : SDO_RANDOM;
                    queue_request(mode, data, count, fill, 1000);
                end
            end
            // long output hold-off while ticks keep coming
            if (first_phase || $urandom_range(0, 2) == 0)
            begin
                repeat ($urandom_range(5, 30)) @(posedge clk);
                long_hold_asks++;
            end
            first_phase = 1'b0;
            wait_drained();
        end

        burst_mode = 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        if (err_count == 0 && predicted_outputs.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
